// File: design/ppp_pkg.sv
// Shared types and constants for the palette pixel packer.
`timescale 1ns / 1ps
package ppp_pkg;

  localparam int PIXEL_W = 32;
  localparam int BYTE_W  = 8;
  localparam int POS_W   = 3;

  // RGBA shade values, red in the top byte
  localparam logic [PIXEL_W-1:0] SHADE_WHITE = 32'hFFFF_FFFF;
  localparam logic [PIXEL_W-1:0] SHADE_LIGHT = 32'hAAAA_AAFF;
  localparam logic [PIXEL_W-1:0] SHADE_DARK  = 32'h5555_55FF;
  localparam logic [PIXEL_W-1:0] SHADE_BLACK = 32'h0000_00FF;

  // shade hit bit positions
  localparam int HIT_WHITE = 0;
  localparam int HIT_LIGHT = 1;
  localparam int HIT_DARK  = 2;
  localparam int HIT_BLACK = 3;

  // operation codes
  localparam logic OP_SURVEY = 1'b0;
  localparam logic OP_PACK   = 1'b1;

  // result kinds
  localparam logic [1:0] KIND_VERDICT = 2'd0;
  localparam logic [1:0] KIND_BYTE    = 2'd1;
  localparam logic [1:0] KIND_REFUSED = 2'd2;

  // verdict / depth codes
  localparam logic [1:0] MODE_NONE = 2'd0;
  localparam logic [1:0] MODE_1BPP = 2'd1;
  localparam logic [1:0] MODE_2BPP = 2'd2;

  typedef struct packed {
    logic [3:0] hit;    // one-hot shade match, zero for any other color
    logic [1:0] code2;  // 2bpp code
  } shade_info_t;

  typedef struct packed {
    logic [1:0]        kind;
    logic [BYTE_W-1:0] data;
    logic [1:0]        bpp;
    logic              done;
  } result_t;

endpackage

// File: design/ppp_classify.sv
// Shade decoder: matches a pixel against the four grey shades.
`timescale 1ns / 1ps
module ppp_classify (
  input  logic [ppp_pkg::PIXEL_W-1:0] pixel,
  output ppp_pkg::shade_info_t        info
);
  import ppp_pkg::*;

  always_comb begin
    info.hit              = '0;
    info.hit[HIT_WHITE]   = (pixel == SHADE_WHITE);
    info.hit[HIT_LIGHT]   = (pixel == SHADE_LIGHT);
    info.hit[HIT_DARK]    = (pixel == SHADE_DARK);
    info.hit[HIT_BLACK]   = (pixel == SHADE_BLACK);
    if (info.hit[HIT_WHITE]) begin
      info.code2 = 2'd0;
    end else if (info.hit[HIT_LIGHT]) begin
      info.code2 = 2'd1;
    end else if (info.hit[HIT_DARK]) begin
      info.code2 = 2'd2;
    end else begin
      info.code2 = 2'd3;
    end
  end

endmodule

// File: design/ppp_core.sv
// Survey/pack state and the per-pixel step logic.
`timescale 1ns / 1ps
module ppp_core (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        step,
  input  logic                        op,
  input  logic                        last,
  input  ppp_pkg::shade_info_t        info,
  output logic                        res_valid,
  output ppp_pkg::result_t            res
);
  import ppp_pkg::*;

  logic [3:0]        seen_r,  seen_nxt;
  logic              foreign_r, foreign_nxt;
  logic [1:0]        mode_r,  mode_nxt;
  logic [BYTE_W-1:0] acc_r,   acc_nxt;
  logic [POS_W-1:0]  pos_r,   pos_nxt;

  logic [3:0]        seen_upd;
  logic              foreign_upd;
  logic [1:0]        code;
  logic [BYTE_W-1:0] acc_new;
  logic [POS_W:0]    npos;

  always_comb begin
    seen_upd    = seen_r | info.hit;
    foreign_upd = foreign_r | (info.hit == 4'd0);
    code        = (mode_r == MODE_1BPP) ? {1'b0, info.hit[HIT_BLACK]} : info.code2;
    acc_new     = acc_r | ({{(BYTE_W-2){1'b0}}, code} << pos_r);
    npos        = {1'b0, pos_r} + {{(POS_W-1){1'b0}}, mode_r};

    seen_nxt    = seen_r;
    foreign_nxt = foreign_r;
    mode_nxt    = mode_r;
    acc_nxt     = acc_r;
    pos_nxt     = pos_r;
    res_valid   = 1'b0;
    res.kind    = KIND_BYTE;
    res.data    = acc_new;
    res.bpp     = mode_r;
    res.done    = last;

    if (op == OP_SURVEY) begin
      seen_nxt    = seen_upd;
      foreign_nxt = foreign_upd;
      if (last) begin
        if (foreign_upd) begin
          mode_nxt = MODE_NONE;
        end else if ((seen_upd & 4'b0110) == 4'd0) begin
          mode_nxt = MODE_1BPP;  // only white and/or black
        end else begin
          mode_nxt = MODE_2BPP;
        end
        seen_nxt    = '0;
        foreign_nxt = 1'b0;
        acc_nxt     = '0;
        pos_nxt     = '0;
        res_valid   = 1'b1;
        res.kind    = KIND_VERDICT;
        res.data    = '0;
        res.bpp     = mode_nxt;
        res.done    = 1'b1;
      end
    end else if (mode_r != MODE_1BPP && mode_r != MODE_2BPP) begin
      // no usable verdict: swallow pixels, refuse at the end
      res_valid = last;
      res.kind  = KIND_REFUSED;
      res.data  = '0;
      res.bpp   = MODE_NONE;
      res.done  = 1'b1;
    end else if (npos[POS_W] || last) begin
      res_valid = 1'b1;
      acc_nxt   = '0;
      pos_nxt   = '0;
    end else begin
      acc_nxt = acc_new;
      pos_nxt = npos[POS_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r    <= '0;
      foreign_r <= 1'b0;
      mode_r    <= MODE_NONE;
      acc_r     <= '0;
      pos_r     <= '0;
    end else if (step) begin
      seen_r    <= seen_nxt;
      foreign_r <= foreign_nxt;
      mode_r    <= mode_nxt;
      acc_r     <= acc_nxt;
      pos_r     <= pos_nxt;
    end
  end

endmodule

// File: design/palette_pixel_packer.sv
// Top level: input register, step logic and result register of the packer.
// Usage:
//  Input stream: in_tdata carries the 32-bit RGBA pixel, in_tuser the operation
//  (0 survey, 1 pack) and in_tlast the final pixel of the pass.
//  Output stream: one word per verdict, packed byte or refusal. out_tuser is
//  the result kind, out_tdata[7:0] the packed byte, out_tdata[9:8] the depth,
//  out_tlast marks the final result of a pass.
//  Send the image once as survey pixels; the last one yields the verdict
//  (depth 0 rejects). Then send it again as pack pixels to get the bytes.
//  Path: a result reaches out_tvalid through the input register, then the
//  result register, after its pixel is taken.
//  Throughput: one pixel per cycle while the receiver keeps out_tready high;
//  the whole step is one compare-and-shift pass between the two registers.
//  Stall: while a result waits in the output register and out_tready is low,
//  the input register takes one more pixel, then holds it and in_tready drops;
//  no word is lost.
//  Reset: rst_n (synchronous, active low) empties both registers and clears
//  the survey flags, verdict and byte accumulator.
`timescale 1ns / 1ps
module palette_pixel_packer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] pixel_value
  input  logic        in_tuser,   // [0] operation
  input  logic        in_tlast,   // last_pixel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [7:0] data_byte, [9:8] bits_per_pixel, rest zero
  output logic [1:0]  out_tuser,  // [1:0] result_kind
  output logic        out_tlast   // pass_done
);
  import ppp_pkg::*;

  logic               s1_valid_r;
  logic [PIXEL_W-1:0] s1_pixel_r;
  logic               s1_op_r;
  logic               s1_last_r;
  logic               out_valid_r, out_valid_nxt;
  result_t            out_res_r;

  logic        go;
  logic        step;
  shade_info_t info;
  logic        res_valid;
  result_t     res;

  // stage 1 may advance whenever the result register is free or draining
  assign go        = !out_valid_r || out_tready;
  assign step      = s1_valid_r && go;
  assign in_tready = !s1_valid_r || go;

  ppp_classify u_classify (
    .pixel (s1_pixel_r),
    .info  (info)
  );

  ppp_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .op        (s1_op_r),
    .last      (s1_last_r),
    .info      (info),
    .res_valid (res_valid),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_pixel_r <= in_tdata;
      s1_op_r    <= in_tuser;
      s1_last_r  <= in_tlast;
    end
  end

  assign out_valid_nxt = go ? (step && res_valid) : out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step && res_valid) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0, out_res_r.bpp, out_res_r.data};
  assign out_tuser  = out_res_r.kind;
  assign out_tlast  = out_res_r.done;

`ifndef SYNTHESIS
  a_stall_only_on_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (out_tvalid && !out_tready))
    else $error("input stalled while result register free");

  a_verdict_form: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser == KIND_VERDICT) |-> (out_tdata[7:0] == 8'd0 && out_tlast))
    else $error("verdict word malformed");

  a_refusal_form: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser == KIND_REFUSED)
      |-> (out_tdata[9:8] == MODE_NONE && out_tdata[7:0] == 8'd0 && out_tlast))
    else $error("refusal word malformed");

  a_byte_depth: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser == KIND_BYTE)
      |-> (out_tdata[9:8] == MODE_1BPP || out_tdata[9:8] == MODE_2BPP))
    else $error("packed byte without a supported depth");

  a_kind_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tuser == KIND_VERDICT || out_tuser == KIND_BYTE ||
                    out_tuser == KIND_REFUSED))
    else $error("unknown result kind");
`endif

endmodule

// File: sim/palette_pixel_packer_test.sv
// Self-checking testbench for the palette pixel packer: directed table, then random images.
`timescale 1ns / 1ps
module palette_pixel_packer_test;
  import ppp_pkg::*;

  localparam int LIMIT_CYCLES = 400000;
  localparam int RANDOM_ITEMS = 1000;
  localparam int HOLD_CYCLES  = 400;

  // 2bpp pixel codes
  localparam logic [1:0] CODE_WHITE = 2'd0;
  localparam logic [1:0] CODE_LIGHT = 2'd1;
  localparam logic [1:0] CODE_DARK  = 2'd2;
  localparam logic [1:0] CODE_OTHER = 2'd3;

  // kinds of random image
  localparam int IMG_MONO  = 0;
  localparam int IMG_GREY  = 1;
  localparam int IMG_MIXED = 2;

  localparam result_t NO_WORD = '{KIND_VERDICT, 8'h00, MODE_NONE, 1'b0};

  typedef struct {
    logic        op;
    logic [31:0] pix;
    logic        last;
    bit          typed;
    bit          has;
    result_t     res;
  } pixel_row_t;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata   = '0;
  logic        in_tuser   = 1'b0;
  logic        in_tlast   = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;
  logic [1:0]  out_tuser;
  logic        out_tlast;

  palette_pixel_packer i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always #1 clk = ~clk;

  // packer state as the testbench tracks it
  logic [3:0] shade_hits   = '0;
  logic       foreign_flag = 1'b0;
  logic [1:0] depth        = MODE_NONE;
  logic [7:0] pack_acc     = '0;
  logic [2:0] pack_pos     = '0;

  result_t    due_words[$];
  int         err_count    = 0;
  int         items_sent   = 0;
  int         burst_left   = 0;
  bit         steady       = 1'b0;
  int         hold_req_cnt = 0;
  int         cycle_count  = 0;

  pixel_row_t directed_pixels[26];

  function automatic logic is_shade(input logic [31:0] pix);
    return pix == SHADE_WHITE || pix == SHADE_LIGHT || pix == SHADE_DARK ||
           pix == SHADE_BLACK;
  endfunction

  function automatic logic [1:0] shade_code(input logic [31:0] pix);
    if (pix == SHADE_WHITE) return CODE_WHITE;
    if (pix == SHADE_LIGHT) return CODE_LIGHT;
    if (pix == SHADE_DARK) return CODE_DARK;
    return CODE_OTHER;
  endfunction

  // one pixel step of the packer; returns 1 when the pixel yields a word
  function automatic bit pack_step(input logic op, input logic [31:0] pix, input logic last,
                                   output result_t res);
    logic [1:0] code;
    logic [7:0] acc_next;
    logic [3:0] npos;
    res = NO_WORD;
    if (op == OP_SURVEY) begin
      if (is_shade(pix)) shade_hits[shade_code(pix)] = 1'b1;
      else foreign_flag = 1'b1;
      if (!last) return 1'b0;
      if (foreign_flag) depth = MODE_NONE;
      else if (!shade_hits[HIT_LIGHT] && !shade_hits[HIT_DARK]) depth = MODE_1BPP;
      else depth = MODE_2BPP;
      shade_hits   = '0;
      foreign_flag = 1'b0;
      pack_acc     = '0;
      pack_pos     = '0;
      res = '{KIND_VERDICT, 8'h00, depth, 1'b1};
      return 1'b1;
    end
    if (depth != MODE_1BPP && depth != MODE_2BPP) begin
      if (!last) return 1'b0;
      res = '{KIND_REFUSED, 8'h00, MODE_NONE, 1'b1};
      return 1'b1;
    end
    if (depth == MODE_1BPP) code = {1'b0, pix == SHADE_BLACK};
    else code = shade_code(pix);
    acc_next = pack_acc | (8'(code) << pack_pos);
    npos = {1'b0, pack_pos} + {2'b00, depth};
    if (npos >= 4'd8 || last) begin
      res = '{KIND_BYTE, acc_next, depth, last};
      pack_acc = '0;
      pack_pos = '0;
      return 1'b1;
    end
    pack_acc = acc_next;
    pack_pos = npos[2:0];
    return 1'b0;
  endfunction

  function automatic logic [31:0] pick_pixel(input int cls);
    logic [31:0] shades[4];
    shades = '{SHADE_WHITE, SHADE_LIGHT, SHADE_DARK, SHADE_BLACK};
    case (cls)
      IMG_MONO: return $urandom_range(0, 1) ? SHADE_BLACK : SHADE_WHITE;
      IMG_GREY: return shades[$urandom_range(0, 3)];
      default: begin
        case ($urandom_range(0, 3))
          0: return $urandom();
          // one bit away from a shade
          1: return shades[$urandom_range(0, 3)] ^ (32'h1 << $urandom_range(0, 31));
          default: return shades[$urandom_range(0, 3)];
        endcase
      end
    endcase
  endfunction

  // queue the word this pixel should give, then offer it until taken
  task automatic send_pixel(input logic op, input logic [31:0] pix, input logic last,
                            input bit typed = 1'b0, input bit typed_has = 1'b0,
                            input result_t typed_word = NO_WORD);
    result_t word;
    bit      has;
    int      gap;
    has = pack_step(op, pix, last, word);
    if (typed) begin
      has  = typed_has;
      word = typed_word;
    end
    if (has) due_words = {due_words, word};
    if (!steady && burst_left == 0) begin
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 12);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    if (burst_left > 0) burst_left--;
    in_tvalid <= 1'b1;
    in_tdata  <= pix;
    in_tuser  <= op;
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
    items_sent++;
  endtask

  // hold the input idle until every queued word has come out
  task automatic drain_words();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (due_words.size() != 0);
  endtask

  // receiver: changing stall patterns, plus a long hold-off on request
  int rx_mode   = 0;
  int mode_left = 0;
  int rx_tick   = 0;
  int hold_seen = 0;
  int hold_left = 0;

  always @(posedge clk) begin
    if (hold_seen != hold_req_cnt) begin
      hold_seen  <= hold_req_cnt;
      hold_left  <= HOLD_CYCLES;
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left  <= hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        rx_mode   <= $urandom_range(0, 3);
        mode_left <= $urandom_range(32, 200);
      end else begin
        mode_left <= mode_left - 1;
      end
      rx_tick <= rx_tick + 1;
      case (rx_mode)
        0: out_tready <= 1'b1;
        1: out_tready <= ($urandom_range(0, 9) < 7);
        2: out_tready <= (rx_tick % 5 != 0);
        default: out_tready <= ($urandom_range(0, 9) < 3);
      endcase
    end
  end

  // compare each word taken with the oldest one due
  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = '{out_tuser, out_tdata[7:0], out_tdata[9:8], out_tlast};
      if (due_words.size() == 0) begin
        $display("%0t: unexpected word, expected none, got kind %0d data %02h bpp %0d last %0b",
                 $time, got.kind, got.data, got.bpp, got.done);
        err_count++;
      end else begin
        want = due_words.pop_front();
        if (got !== want) begin
          $display({"%0t: mismatch, expected kind %0d data %02h bpp %0d last %0b,",
                    " got kind %0d data %02h bpp %0d last %0b"},
                   $time, want.kind, want.data, want.bpp, want.done,
                   got.kind, got.data, got.bpp, got.done);
          err_count++;
        end
      end
    end
  end

  initial begin
    while (cycle_count < LIMIT_CYCLES) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("simulation failed");
    $finish;
  end

  initial begin
    logic [31:0] img[$];
    int          cls;
    int          len;
    int          passes;
    int          img_count;
    logic [31:0] pix;

    img_count = 0;
    directed_pixels = '{
      // refusal straight after reset
      '{OP_PACK,   SHADE_BLACK,   1'b1, 1'b1, 1'b1, '{KIND_REFUSED, 8'h00, MODE_NONE, 1'b1}},
      '{OP_PACK,   SHADE_WHITE,   1'b0, 1'b1, 1'b0, NO_WORD},
      '{OP_SURVEY, SHADE_WHITE,   1'b0, 1'b1, 1'b0, NO_WORD},
      '{OP_SURVEY, SHADE_BLACK,   1'b1, 1'b1, 1'b1, '{KIND_VERDICT, 8'h00, MODE_1BPP, 1'b1}},
      // 1bpp full byte, non-shades coded as white
      '{OP_PACK,   SHADE_BLACK,   1'b0, 1'b0, 1'b0, NO_WORD},
      '{OP_PACK,   SHADE_WHITE,   1'b0, 1'b0, 1'b0, NO_WORD},
      '{OP_PACK,   SHADE_BLACK,   1'b0, 1'b0, 1'b0, NO_WORD},
      '{OP_PACK,   SHADE_BLACK,   1'b0, 1'b0, 1'b0, NO_WORD},
      '{OP_PACK,   SHADE_LIGHT,   1'b0, 1'b0, 1'b0, NO_WORD},
      '{OP_PACK,   32'hFFFF_FF00, 1'b0, 1'b0, 1'b0, NO_WORD},
      '{OP_PACK,   SHADE_BLACK,   1'b0, 1'b0, 1'b0, NO_WORD},
      '{OP_PACK,   SHADE_BLACK,   1'b0, 1'b0, 1'b0, NO_WORD},
      // partial byte flushed on the last pixel
      '{OP_PACK,   SHADE_BLACK,   1'b1, 1'b1, 1'b1, '{KIND_BYTE, 8'h01, MODE_1BPP, 1'b1}},
      '{OP_SURVEY, SHADE_LIGHT,   1'b0, 1'b1, 1'b0, NO_WORD},
      '{OP_SURVEY, SHADE_DARK,    1'b1, 1'b1, 1'b1, '{KIND_VERDICT, 8'h00, MODE_2BPP, 1'b1}},
      '{OP_PACK,   SHADE_WHITE,   1'b0, 1'b0, 1'b0, NO_WORD},
      '{OP_PACK,   SHADE_LIGHT,   1'b0, 1'b0, 1'b0, NO_WORD},
      '{OP_PACK,   SHADE_DARK,    1'b0, 1'b0, 1'b0, NO_WORD},
      '{OP_PACK,   32'h1234_5678, 1'b0, 1'b1, 1'b1, '{KIND_BYTE, 8'hE4, MODE_2BPP, 1'b0}},
      '{OP_PACK,   SHADE_LIGHT,   1'b1, 1'b1, 1'b1, '{KIND_BYTE, 8'h01, MODE_2BPP, 1'b1}},
      // foreign color rejects, then packing is refused
      '{OP_SURVEY, 32'h0000_0000, 1'b1, 1'b1, 1'b1, '{KIND_VERDICT, 8'h00, MODE_NONE, 1'b1}},
      '{OP_PACK,   32'hFFFF_FFFE, 1'b1, 1'b1, 1'b1, '{KIND_REFUSED, 8'h00, MODE_NONE, 1'b1}},
      // stray survey pixel inside a pack pass keeps the accumulator
      '{OP_SURVEY, SHADE_BLACK,   1'b1, 1'b1, 1'b1, '{KIND_VERDICT, 8'h00, MODE_1BPP, 1'b1}},
      '{OP_PACK,   SHADE_BLACK,   1'b0, 1'b0, 1'b0, NO_WORD},
      '{OP_SURVEY, SHADE_LIGHT,   1'b0, 1'b0, 1'b0, NO_WORD},
      '{OP_PACK,   SHADE_BLACK,   1'b1, 1'b1, 1'b1, '{KIND_BYTE, 8'h03, MODE_1BPP, 1'b1}}
    };

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int r = 0; r < $size(directed_pixels); r++) begin
      send_pixel(directed_pixels[r].op, directed_pixels[r].pix, directed_pixels[r].last,
                 directed_pixels[r].typed, directed_pixels[r].has, directed_pixels[r].res);
    end
    drain_words();

    items_sent = 0;
    while (items_sent < RANDOM_ITEMS) begin
      img_count++;
      if ($urandom_range(0, 9) == 0) begin
        // noise: any operation, any pixel, any last flag
        repeat ($urandom_range(1, 8)) begin
          pix = $urandom_range(0, 1) ? $urandom() : pick_pixel(IMG_GREY);
          send_pixel(1'($urandom_range(0, 1)), pix, $urandom_range(0, 3) == 0);
        end
      end else begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3: cls = IMG_MONO;
          4, 5, 6, 7: cls = IMG_GREY;
          default: cls = IMG_MIXED;
        endcase
        len = ($urandom_range(0, 15) == 0) ? $urandom_range(25, 64) : $urandom_range(1, 12);
        img.delete();
        for (int i = 0; i < len; i++) img = {img, pick_pixel(cls)};
        for (int i = 0; i < len; i++) send_pixel(OP_SURVEY, img[i], i == len - 1);
        passes = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 2);
        for (int p = 0; p < passes; p++) begin
          for (int i = 0; i < len; i++) begin
            pix = ($urandom_range(0, 19) == 0) ? pick_pixel(IMG_MIXED) : img[i];
            if ($urandom_range(0, 29) == 0) send_pixel(OP_SURVEY, pick_pixel(cls), 1'b0);
            send_pixel(OP_PACK, pix, i == len - 1);
          end
        end
      end

      if (img_count == 40) begin
        // receiver holds off while verdict words pile up
        hold_req_cnt <= hold_req_cnt + 1;
        steady = 1'b1;
        repeat (20) send_pixel(OP_SURVEY, pick_pixel($urandom_range(0, 2)), 1'b1);
        steady = 1'b0;
      end
      if (img_count == 20 || $urandom_range(0, 11) == 0) drain_words();
    end

    drain_words();
    repeat (8) @(posedge clk);
    if (err_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// File: files.f
design/ppp_pkg.sv
design/ppp_classify.sv
design/ppp_core.sv
design/palette_pixel_packer.sv
sim/palette_pixel_packer_test.sv
